@@ design/laplace_grid_relaxation_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Laplace grid relaxation core
// Shared concurrent assertion forms clocked on clk with synchronous rst.
// ----------------------------------------------------------------------------
`ifndef LAPLACE_GRID_RELAXATION_CORE_ASSERT_SVH
`define LAPLACE_GRID_RELAXATION_CORE_ASSERT_SVH

// Checked outside reset only.
`define LRC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed in laplace grid relaxation core");

// Checked on every edge, reset included.
`define LRC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed in laplace grid relaxation core");

`endif

@@ design/lrc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrc_pkg
// Types and constants shared by the Laplace grid relaxation core.
// ----------------------------------------------------------------------------
package lrc_pkg;

  localparam int VAL_W = 32;
  localparam int GRID_SIDE_DEF = 8;
  localparam logic [VAL_W-1:0] BOUNDARY_RESET = 32'h0A00_0000;
  localparam logic [VAL_W-1:0] TOLERANCE_RESET = 32'd16;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_SWEEP = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    REG_BOUNDARY  = 2'd0,
    REG_TOLERANCE = 2'd1,
    REG_METHOD    = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [2:0] row;
    logic [2:0] col;
  } cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0] cell_value;
    logic [VAL_W-1:0] centre_gap;
    logic             converged;
    logic [VAL_W-1:0] sweep_count;
    logic             bad_index;
  } result_t;

  // Per-step control from the sequencer to the update unit.
  typedef struct packed {
    logic shift;
    logic init;
    logic sweep;
    logic gauss;
    logic interior;
    logic on_edge;
  } step_ctl_t;

endpackage

@@ design/laplace_grid_relaxation_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laplace_grid_relaxation_core
// Laplace relaxation on a square grid held in a circular chain of cells.
// ----------------------------------------------------------------------------
// The result strobe of every command rises after the grid has rotated once
// through the cell chain, one cell per cycle passing the single update unit,
// followed by the finish state that forms the result and then the done
// register; busy stays high until the strobe. The result beat appears on
// result for exactly one cycle with done high and cannot be held off, so the
// receiver must take it in that cycle. Busy is already low in the strobe
// cycle, so the next command can be accepted at the edge that takes the
// result beat. Configuration writes are taken at any time but are meant for
// when busy is low; a new boundary value only reaches the grid edges at the
// next init command.
// ----------------------------------------------------------------------------
module laplace_grid_relaxation_core #(
  parameter int GRID_SIDE = lrc_pkg::GRID_SIDE_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  lrc_pkg::cmd_t             cmd,
  output logic                      done,
  output lrc_pkg::result_t          result,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [lrc_pkg::VAL_W-1:0] cfg_data
);

  `include "laplace_grid_relaxation_core_assert.svh"

  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int CW = $clog2(GRID_SIDE);
  localparam logic [CW-1:0] LAST = CW'(GRID_SIDE - 1);
  localparam logic [CW-1:0] MID = CW'(GRID_SIDE / 2);

  // Configuration registers.
  logic [lrc_pkg::VAL_W-1:0] boundary;
  logic [lrc_pkg::VAL_W-1:0] tolerance;
  logic                      method;

  always_ff @(posedge clk) begin
    if (rst) begin
      boundary  <= lrc_pkg::BOUNDARY_RESET;
      tolerance <= lrc_pkg::TOLERANCE_RESET;
      method    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lrc_pkg::REG_BOUNDARY:  boundary  <= cfg_data;
        lrc_pkg::REG_TOLERANCE: tolerance <= cfg_data;
        lrc_pkg::REG_METHOD:    method    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer.
  lrc_pkg::state_t state, state_next;
  lrc_pkg::cmd_t   cmd_q;
  logic [CW-1:0]   rcnt;
  logic [CW-1:0]   ccnt;
  logic            accept;
  logic            last_step;
  logic            shift;
  logic [lrc_pkg::VAL_W-1:0] sweeps;

  assign accept    = start && !busy;
  assign last_step = (rcnt == LAST) && (ccnt == LAST);

  always_comb begin
    state_next = state;
    unique case (state)
      lrc_pkg::ST_IDLE:   if (start) state_next = lrc_pkg::ST_RUN;
      lrc_pkg::ST_RUN:    if (last_step) state_next = lrc_pkg::ST_FINISH;
      lrc_pkg::ST_FINISH: state_next = lrc_pkg::ST_IDLE;
      default:            state_next = lrc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy  = (state != lrc_pkg::ST_IDLE);
    shift = (state == lrc_pkg::ST_RUN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= lrc_pkg::ST_IDLE;
      rcnt   <= '0;
      ccnt   <= '0;
      sweeps <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        rcnt <= '0;
        ccnt <= '0;
        if (cmd.opcode == lrc_pkg::OP_INIT) begin
          sweeps <= '0;
        end else if (cmd.opcode == lrc_pkg::OP_SWEEP && sweeps != '1) begin
          sweeps <= sweeps + 1'b1;
        end
      end else if (shift) begin
        if (ccnt == LAST) begin
          ccnt <= '0;
          rcnt <= rcnt + 1'b1;
        end else begin
          ccnt <= ccnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
    end
  end

  // Cell chain: position 0 is the head, the update unit feeds the tail.
  logic [lrc_pkg::VAL_W-1:0] cval [CELLS];
  logic [lrc_pkg::VAL_W-1:0] tail;
  lrc_pkg::step_ctl_t        ctl;

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    localparam bit ON_EDGE = (i / GRID_SIDE == 0) || (i / GRID_SIDE == GRID_SIDE - 1) ||
                             (i % GRID_SIDE == 0) || (i % GRID_SIDE == GRID_SIDE - 1);
    lrc_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (shift),
      .rst_val (ON_EDGE ? lrc_pkg::BOUNDARY_RESET : '0),
      .d       ((i == CELLS - 1) ? tail : cval[(i + 1) % CELLS]),
      .q       (cval[i])
    );
  end

  always_comb begin
    ctl.shift    = shift;
    ctl.init     = (cmd_q.opcode == lrc_pkg::OP_INIT);
    ctl.sweep    = (cmd_q.opcode == lrc_pkg::OP_SWEEP);
    ctl.gauss    = method;
    ctl.on_edge  = (rcnt == '0) || (rcnt == LAST) || (ccnt == '0) || (ccnt == LAST);
    ctl.interior = !ctl.on_edge;
  end

  // Up and left neighbors have already passed the head this rotation, so they
  // sit near the tail; down and right are still ahead of the head.
  lrc_stencil #(
    .GRID_SIDE (GRID_SIDE)
  ) u_stencil (
    .clk      (clk),
    .ctl      (ctl),
    .boundary (boundary),
    .head     (cval[0]),
    .right    (cval[1]),
    .down     (cval[GRID_SIDE]),
    .left_new (cval[CELLS-1]),
    .up_new   (cval[CELLS-GRID_SIDE]),
    .tail     (tail)
  );

  // Capture the centre and the requested cell as they leave the update unit.
  logic [lrc_pkg::VAL_W-1:0] centre_q;
  logic [lrc_pkg::VAL_W-1:0] read_q;

  always_ff @(posedge clk) begin
    if (shift) begin
      if (rcnt == MID && ccnt == MID) begin
        centre_q <= tail;
      end
      if (32'(rcnt) == 32'(cmd_q.row) && 32'(ccnt) == 32'(cmd_q.col)) begin
        read_q <= tail;
      end
    end
  end

  // Result formation in the finish cycle.
  logic                      bad;
  logic [lrc_pkg::VAL_W-1:0] gap;

  always_comb begin
    bad = (cmd_q.opcode == lrc_pkg::OP_READ) &&
          (32'(cmd_q.row) >= 32'(GRID_SIDE) || 32'(cmd_q.col) >= 32'(GRID_SIDE));
    gap = (boundary > centre_q) ? boundary - centre_q : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == lrc_pkg::ST_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    if (state == lrc_pkg::ST_FINISH) begin
      if (cmd_q.opcode == lrc_pkg::OP_READ) begin
        result.cell_value <= bad ? '0 : read_q;
      end else begin
        result.cell_value <= centre_q;
      end
      result.centre_gap  <= gap;
      result.converged   <= (gap <= tolerance);
      result.sweep_count <= sweeps;
      result.bad_index   <= bad;
    end
  end

  // A result beat only ends a command, and the block is free when it shows.
  `LRC_ASSERT(a_done_idle, done |-> !busy)
  `LRC_ASSERT(a_done_after_busy, done |-> $past(busy))
  `LRC_ASSERT(a_accept_busy, (start && !busy) |=> busy)
  `LRC_ASSERT(a_bad_zero, (done && result.bad_index) |-> (result.cell_value == '0))

endmodule

@@ design/lrc_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrc_cell
// One grid cell of the circular chain; takes its neighbor's value on shift.
// ----------------------------------------------------------------------------
module lrc_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         shift,
  input  logic [lrc_pkg::VAL_W-1:0]    rst_val,
  input  logic [lrc_pkg::VAL_W-1:0]    d,
  output logic [lrc_pkg::VAL_W-1:0]    q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= rst_val;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

@@ design/lrc_stencil.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrc_stencil
// Computes the value that re-enters the chain tail for the cell at the head.
// ----------------------------------------------------------------------------
module lrc_stencil #(
  parameter int GRID_SIDE = lrc_pkg::GRID_SIDE_DEF
) (
  input  logic                      clk,
  input  lrc_pkg::step_ctl_t        ctl,
  input  logic [lrc_pkg::VAL_W-1:0] boundary,
  input  logic [lrc_pkg::VAL_W-1:0] head,
  input  logic [lrc_pkg::VAL_W-1:0] right,
  input  logic [lrc_pkg::VAL_W-1:0] down,
  input  logic [lrc_pkg::VAL_W-1:0] left_new,
  input  logic [lrc_pkg::VAL_W-1:0] up_new,
  output logic [lrc_pkg::VAL_W-1:0] tail
);

  // Pre-update values of the last GRID_SIDE cells that left the head.
  logic [lrc_pkg::VAL_W-1:0] old_line [GRID_SIDE];
  logic [lrc_pkg::VAL_W-1:0] up;
  logic [lrc_pkg::VAL_W-1:0] left;
  logic [lrc_pkg::VAL_W+1:0] sum;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      old_line[0] <= head;
      for (int i = 1; i < GRID_SIDE; i++) begin
        old_line[i] <= old_line[i-1];
      end
    end
  end

  always_comb begin
    up   = ctl.gauss ? up_new : old_line[GRID_SIDE-1];
    left = ctl.gauss ? left_new : old_line[0];
    sum  = {2'b00, up} + {2'b00, down} + {2'b00, left} + {2'b00, right};
    if (ctl.init) begin
      tail = ctl.on_edge ? boundary : '0;
    end else if (ctl.sweep && ctl.interior) begin
      tail = sum[lrc_pkg::VAL_W+1:2];
    end else begin
      tail = head;
    end
  end

endmodule
